FILE: rtl/wtts_pkg.sv
// Shared types and constants for the window tick time statistics block.
// Used by the controller, the datapath, the top level and the checker.
package wtts_pkg;

   localparam int WINDOW      = 20;
   localparam int SAMPLE_BITS = 24;

   localparam int SLOT_BITS  = $clog2(WINDOW);
   localparam int COUNT_BITS = $clog2(WINDOW + 1);
   localparam int SUM_BITS   = SAMPLE_BITS + COUNT_BITS;

   localparam int REQ_DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((5 * SAMPLE_BITS + 7) / 8) * 8;

   // divider lanes
   localparam int LANES     = 3;
   localparam int LANE_MEAN = 0;
   localparam int LANE_EVEN = 1;
   localparam int LANE_ODD  = 2;
   localparam int LANE_BITS = $clog2(LANES);

   // q = (x * ceil(2^RECIP_SHIFT / d)) >> RECIP_SHIFT, exact for every x below
   // 2^SUM_BITS because every divisor stays below 2^COUNT_BITS.
   localparam int RECIP_SHIFT = SUM_BITS + COUNT_BITS;
   localparam int RECIP_BITS  = RECIP_SHIFT - $clog2(WINDOW / 2) + 1;
   localparam logic [63:0] RECIP_ONE = 64'd1 << RECIP_SHIFT;

   localparam logic [RECIP_BITS-1:0] RECIP [LANES] = '{
      RECIP_BITS'((RECIP_ONE + 64'(WINDOW - 1)) / 64'(WINDOW)),
      RECIP_BITS'((RECIP_ONE + 64'((WINDOW + 1) / 2 - 1)) / 64'((WINDOW + 1) / 2)),
      RECIP_BITS'((RECIP_ONE + 64'(WINDOW / 2 - 1)) / 64'(WINDOW / 2))
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DIV_LOAD,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic accept;
      logic scan_issue;
      logic div_load;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
      logic div_last;
      logic out_busy;
   } stat_type;

endpackage

FILE: rtl/window_tick_time_stats.sv
// A sample goes through a scan of the filled entries (1..20), a drain state, the divider load
// and the divide steps, and is registered at the output before the next is taken; the ring scan
// reads one entry per cycle and the divider forms one quotient per cycle by reciprocal multiply.
// A result waiting in the output register does not block the next input transfer.
// Reset clears write slot, fill count, sequencer and output valid; ring contents stay
// undefined until written, with no clearing pass.
module window_tick_time_stats (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [wtts_pkg::REQ_DATA_BITS-1:0]   req_tdata,  // sample_us
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // window_mean, window_min, window_max, pair_low, pair_high
   output logic [wtts_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   output logic [0:0]                           rsp_tuser   // window_full
);

   localparam int SB = wtts_pkg::SAMPLE_BITS;

   wtts_pkg::cmd_type  cmd;
   wtts_pkg::stat_type stat;
   logic          rsp_take;
   logic [SB-1:0] window_mean, window_min, window_max, pair_low, pair_high;
   logic          window_full;

   assign rsp_take = rsp_tvalid && rsp_tready;

   wtts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   wtts_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .sample_us   (req_tdata[SB-1:0]),
      .rsp_take    (rsp_take),
      .rsp_valid   (rsp_tvalid),
      .window_mean (window_mean),
      .window_min  (window_min),
      .window_max  (window_max),
      .pair_low    (pair_low),
      .pair_high   (pair_high),
      .window_full (window_full)
   );

   assign rsp_tdata = wtts_pkg::RSP_DATA_BITS'({pair_high, pair_low, window_max,
                                                window_min, window_mean});
   assign rsp_tuser = window_full;

endmodule

FILE: rtl/wtts_ctrl.sv
// Sequencer for the window statistics block: scan, divide, hand off.
// Depends on wtts_pkg for the state, command and status types.
module wtts_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  wtts_pkg::stat_type stat,
   output wtts_pkg::cmd_type  cmd
);

   wtts_pkg::state_type state_ff;
   wtts_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wtts_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wtts_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = wtts_pkg::ST_SCAN;
         end
         wtts_pkg::ST_SCAN: begin
            if (stat.scan_last) state_in = wtts_pkg::ST_DRAIN;
         end
         wtts_pkg::ST_DRAIN: begin
            state_in = wtts_pkg::ST_DIV_LOAD;
         end
         wtts_pkg::ST_DIV_LOAD: begin
            state_in = wtts_pkg::ST_DIVIDE;
         end
         wtts_pkg::ST_DIVIDE: begin
            if (stat.div_last) state_in = wtts_pkg::ST_FINISH;
         end
         wtts_pkg::ST_FINISH: begin
            if (!stat.out_busy) state_in = wtts_pkg::ST_IDLE;
         end
         default: begin
            state_in = wtts_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready     = 1'b0;
      cmd.accept     = 1'b0;
      cmd.scan_issue = 1'b0;
      cmd.div_load   = 1'b0;
      cmd.div_step   = 1'b0;
      cmd.out_load   = 1'b0;
      case (state_ff)
         wtts_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         wtts_pkg::ST_SCAN: begin
            cmd.scan_issue = 1'b1;
         end
         wtts_pkg::ST_DRAIN: begin
         end
         wtts_pkg::ST_DIV_LOAD: begin
            cmd.div_load = 1'b1;
         end
         wtts_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         wtts_pkg::ST_FINISH: begin
            cmd.out_load = !stat.out_busy;
         end
         default: begin
         end
      endcase
   end

endmodule

FILE: rtl/wtts_datapath.sv
// Datapath: sample ring, scan accumulators, three-lane reciprocal divider
// and the output register. Depends on wtts_pkg; driven by wtts_ctrl.
module wtts_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  wtts_pkg::cmd_type                cmd,
   output wtts_pkg::stat_type               stat,
   input  logic [wtts_pkg::SAMPLE_BITS-1:0] sample_us,
   input  logic                             rsp_take,
   output logic                             rsp_valid,
   output logic [wtts_pkg::SAMPLE_BITS-1:0] window_mean,
   output logic [wtts_pkg::SAMPLE_BITS-1:0] window_min,
   output logic [wtts_pkg::SAMPLE_BITS-1:0] window_max,
   output logic [wtts_pkg::SAMPLE_BITS-1:0] pair_low,
   output logic [wtts_pkg::SAMPLE_BITS-1:0] pair_high,
   output logic                             window_full
);

   localparam int SB  = wtts_pkg::SAMPLE_BITS;
   localparam int UB  = wtts_pkg::SUM_BITS;
   localparam int CB  = wtts_pkg::COUNT_BITS;
   localparam int LB  = wtts_pkg::SLOT_BITS;
   localparam int NB  = wtts_pkg::LANE_BITS;
   localparam int PB  = UB + wtts_pkg::RECIP_BITS;

   logic [SB-1:0] ring_mem [wtts_pkg::WINDOW];
   logic [SB-1:0] rd_data_ff;

   logic [LB-1:0] write_slot_ff, write_slot_in;
   logic [CB-1:0] fill_count_ff, fill_count_in;
   logic [LB-1:0] scan_idx_ff, scan_idx_in;
   logic          rd_valid_ff, rd_valid_in;
   logic          rd_odd_ff, rd_odd_in;
   logic          rd_first_ff, rd_first_in;
   logic [UB-1:0] sum_ff, sum_in;
   logic [UB-1:0] even_ff, even_in;
   logic [UB-1:0] odd_ff, odd_in;
   logic [SB-1:0] lo_ff, lo_in;
   logic [SB-1:0] hi_ff, hi_in;
   logic [UB-1:0] quo_ff [wtts_pkg::LANES];
   logic [UB-1:0] quo_in [wtts_pkg::LANES];
   logic [PB-1:0] product;
   logic [UB-1:0] quotient;
   logic [NB-1:0] div_cnt_ff, div_cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [SB-1:0] mean_ff, mean_in;
   logic [SB-1:0] min_ff, min_in;
   logic [SB-1:0] max_ff, max_in;
   logic [SB-1:0] low_ff, low_in;
   logic [SB-1:0] high_ff, high_in;
   logic          full_ff, full_in;
   logic          full_now;
   logic [SB-1:0] even_q, odd_q;

   // ring: write on accept, registered read during scan
   always_ff @(posedge clock) begin
      if (cmd.accept) ring_mem[write_slot_ff] <= sample_us;
      if (cmd.scan_issue) rd_data_ff <= ring_mem[scan_idx_ff];
   end

   always_comb begin
      write_slot_in = write_slot_ff;
      fill_count_in = fill_count_ff;
      scan_idx_in   = scan_idx_ff;
      rd_valid_in   = cmd.scan_issue;
      rd_odd_in     = scan_idx_ff[0];
      rd_first_in   = rd_first_ff;
      sum_in        = sum_ff;
      even_in       = even_ff;
      odd_in        = odd_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;

      if (cmd.accept) begin
         write_slot_in = (write_slot_ff == LB'(wtts_pkg::WINDOW - 1)) ?
                         '0 : write_slot_ff + LB'(1);
         if (fill_count_ff < CB'(wtts_pkg::WINDOW)) fill_count_in = fill_count_ff + CB'(1);
         scan_idx_in = '0;
         rd_first_in = 1'b1;
         sum_in      = '0;
         even_in     = '0;
         odd_in      = '0;
      end else if (cmd.scan_issue) begin
         scan_idx_in = scan_idx_ff + LB'(1);
      end

      // fold in the entry read last cycle
      if (rd_valid_ff) begin
         rd_first_in = 1'b0;
         sum_in = sum_ff + UB'(rd_data_ff);
         if (rd_odd_ff) odd_in = odd_ff + UB'(rd_data_ff);
         else even_in = even_ff + UB'(rd_data_ff);
         if (rd_first_ff || rd_data_ff < lo_ff) lo_in = rd_data_ff;
         if (rd_first_ff || rd_data_ff > hi_ff) hi_in = rd_data_ff;
      end
   end

   // one lane per cycle through a shared reciprocal multiplier
   always_comb begin
      div_cnt_in = div_cnt_ff;
      product    = PB'(quo_ff[div_cnt_ff]) * PB'(wtts_pkg::RECIP[div_cnt_ff]);
      quotient   = UB'(product[PB-1:wtts_pkg::RECIP_SHIFT]);
      for (int k = 0; k < wtts_pkg::LANES; k++) quo_in[k] = quo_ff[k];
      if (cmd.div_load) begin
         quo_in[wtts_pkg::LANE_MEAN] = sum_ff;
         quo_in[wtts_pkg::LANE_EVEN] = even_ff;
         quo_in[wtts_pkg::LANE_ODD]  = odd_ff;
         div_cnt_in = '0;
      end else if (cmd.div_step) begin
         for (int k = 0; k < wtts_pkg::LANES; k++) begin
            if (div_cnt_ff == NB'(k)) quo_in[k] = quotient;
         end
         div_cnt_in = div_cnt_ff + NB'(1);
      end
   end

   assign full_now = (fill_count_ff == CB'(wtts_pkg::WINDOW));
   assign even_q   = quo_ff[wtts_pkg::LANE_EVEN][SB-1:0];
   assign odd_q    = quo_ff[wtts_pkg::LANE_ODD][SB-1:0];

   always_comb begin
      mean_in = mean_ff;
      min_in  = min_ff;
      max_in  = max_ff;
      low_in  = low_ff;
      high_in = high_ff;
      full_in = full_ff;
      rsp_valid_in = rsp_take ? 1'b0 : rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         mean_in = quo_ff[wtts_pkg::LANE_MEAN][SB-1:0];
         min_in  = lo_ff;
         max_in  = hi_ff;
         full_in = full_now;
         if (!full_now) begin
            low_in  = '0;
            high_in = '0;
         end else if (even_q > odd_q) begin
            low_in  = odd_q;
            high_in = even_q;
         end else begin
            low_in  = even_q;
            high_in = odd_q;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_slot_ff <= '0;
         fill_count_ff <= '0;
         rd_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         div_cnt_ff    <= '0;
      end else begin
         write_slot_ff <= write_slot_in;
         fill_count_ff <= fill_count_in;
         rd_valid_ff   <= rd_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         div_cnt_ff    <= div_cnt_in;
      end
      scan_idx_ff <= scan_idx_in;
      rd_odd_ff   <= rd_odd_in;
      rd_first_ff <= rd_first_in;
      sum_ff      <= sum_in;
      even_ff     <= even_in;
      odd_ff      <= odd_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      for (int k = 0; k < wtts_pkg::LANES; k++) begin
         quo_ff[k] <= quo_in[k];
      end
      mean_ff <= mean_in;
      min_ff  <= min_in;
      max_ff  <= max_in;
      low_ff  <= low_in;
      high_ff <= high_in;
      full_ff <= full_in;
   end

   assign stat.scan_last = ((CB'(scan_idx_ff) + CB'(1)) == fill_count_ff);
   assign stat.div_last  = (div_cnt_ff == NB'(wtts_pkg::LANES - 1));
   assign stat.out_busy  = rsp_valid_ff && !rsp_take;

   assign rsp_valid   = rsp_valid_ff;
   assign window_mean = mean_ff;
   assign window_min  = min_ff;
   assign window_max  = max_ff;
   assign pair_low    = low_ff;
   assign pair_high   = high_ff;
   assign window_full = full_ff;

endmodule

FILE: rtl/wtts_checker.sv
// Port-level checks on the window statistics block, bound to the top level.
// Depends on wtts_pkg for the field widths.
module wtts_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [wtts_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input logic [0:0]                         rsp_tuser
);

   localparam int SB = wtts_pkg::SAMPLE_BITS;

   logic [SB-1:0] mean_w, min_w, max_w, low_w, high_w;

   assign mean_w = rsp_tdata[SB-1:0];
   assign min_w  = rsp_tdata[2*SB-1:SB];
   assign max_w  = rsp_tdata[3*SB-1:2*SB];
   assign low_w  = rsp_tdata[4*SB-1:3*SB];
   assign high_w = rsp_tdata[5*SB-1:4*SB];

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_min_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> min_w <= max_w)
      else $error("window minimum above maximum");

   a_mean_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> mean_w <= max_w)
      else $error("window mean above maximum");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> low_w <= high_w)
      else $error("pair averages out of order");

   a_pair_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> low_w == '0 && high_w == '0)
      else $error("pair averages nonzero before window full");

endmodule

bind window_tick_time_stats wtts_checker u_wtts_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Testbench for window_tick_time_stats: a directed table, then random tick samples, each
// result held to a typed row or a model of the 20-entry window mean, min, max and pairs.
// Depends on rtl/wtts_pkg.sv and rtl/window_tick_time_stats.sv.
module tb;
   import wtts_pkg::*;

   typedef logic [SAMPLE_BITS-1:0] sample_t;
   typedef logic [SUM_BITS-1:0]    sum_t;

   typedef struct packed {
      sample_t mean;
      sample_t low_sample;
      sample_t high_sample;
      sample_t pair_low;
      sample_t pair_high;
      logic    full;
   } window_stats_t;

   typedef struct packed {
      sample_t       sample;
      logic          typed;   // stats below are literal, not predicted
      window_stats_t stats;
   } stim_row_t;

   typedef enum logic [1:0] {
      FLOW_FREE,
      FLOW_SEND_IDLE,
      FLOW_RECV_STALL,
      FLOW_BOTH
   } flow_t;

   localparam int RANDOM_SAMPLES  = 850;
   localparam int HOLD_OFF_AT     = 400;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int DRAIN_CYCLES    = 60;
   localparam int MAX_REPORTS     = 40;
   localparam int DIRECTED_ROWS   = 24;

   // Fill the window with full-scale values on even slots and zeros on odd slots,
   // then wrap and overwrite the oldest entries.
   localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
      '{24'hFFFFFF, 1'b1, '{24'h0CCCCC, 24'hFFFFFF, 24'hFFFFFF, 24'h0, 24'h0, 1'b0}},
      '{24'h000000, 1'b1, '{24'h0CCCCC, 24'h000000, 24'hFFFFFF, 24'h0, 24'h0, 1'b0}},
      '{24'hFFFFFF, 1'b0, '0},
      '{24'h000000, 1'b0, '0},
      '{24'hFFFFFF, 1'b0, '0},
      '{24'h000000, 1'b0, '0},
      '{24'hFFFFFF, 1'b0, '0},
      '{24'h000000, 1'b0, '0},
      '{24'hFFFFFF, 1'b0, '0},
      '{24'h000000, 1'b0, '0},
      '{24'hFFFFFF, 1'b0, '0},
      '{24'h000000, 1'b0, '0},
      '{24'hFFFFFF, 1'b0, '0},
      '{24'h000000, 1'b0, '0},
      '{24'hFFFFFF, 1'b0, '0},
      '{24'h000000, 1'b0, '0},
      '{24'hFFFFFF, 1'b0, '0},
      '{24'h000000, 1'b0, '0},
      '{24'hFFFFFF, 1'b0, '0},
      '{24'h000000, 1'b1, '{24'h7FFFFF, 24'h000000, 24'hFFFFFF, 24'h0, 24'hFFFFFF, 1'b1}},
      '{24'h000000, 1'b0, '0},
      '{24'hFFFFFF, 1'b0, '0},
      '{24'h000001, 1'b0, '0},
      '{24'h800000, 1'b0, '0}
   };

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic [0:0]               rsp_tuser;

   window_stats_t pending_stats [$];
   int            mismatches = 0;
   flow_t         flow = FLOW_FREE;
   bit            hold_off_pending = 1'b0;

   // window model state
   sample_t     window_ring [WINDOW];
   int unsigned next_slot = 0;
   int unsigned filled = 0;
   sample_t     steady_value = '0;

   window_tick_time_stats dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #1_000_000;
      $display("Some tests failed");
      $finish;
   end

   // Write one sample into the window and return the statistics after the write.
   function automatic window_stats_t push_sample(sample_t s);
      sum_t          total;
      sum_t          even_total;
      sum_t          odd_total;
      sample_t       even_avg;
      sample_t       odd_avg;
      window_stats_t r;
      int unsigned   i;
      total      = '0;
      even_total = '0;
      odd_total  = '0;
      r          = '0;
      window_ring[next_slot] = s;
      next_slot = (next_slot + 1 == WINDOW) ? 0 : next_slot + 1;
      if (filled < WINDOW) filled++;
      r.low_sample  = window_ring[0];
      r.high_sample = window_ring[0];
      for (i = 0; i < filled; i++) begin
         total += window_ring[i];
         if (window_ring[i] < r.low_sample) r.low_sample = window_ring[i];
         if (window_ring[i] > r.high_sample) r.high_sample = window_ring[i];
         if (i[0]) odd_total += window_ring[i];
         else even_total += window_ring[i];
      end
      r.mean = sample_t'(total / WINDOW);
      if (filled == WINDOW) begin
         even_avg    = sample_t'(even_total / ((WINDOW + 1) / 2));
         odd_avg     = sample_t'(odd_total / (WINDOW / 2));
         r.pair_low  = (even_avg > odd_avg) ? odd_avg : even_avg;
         r.pair_high = (even_avg > odd_avg) ? even_avg : odd_avg;
         r.full      = 1'b1;
      end
      return r;
   endfunction

   function automatic sample_t random_sample();
      case ($urandom_range(9))
         0, 1, 2, 3: return sample_t'($urandom);
         4, 5:       return sample_t'($urandom_range(2000));
         6:          return $urandom_range(1) ? '1 : '0;
         default: begin
            // repeat one value for a while so whole windows tie
            if ($urandom_range(15) == 0) steady_value = sample_t'($urandom);
            return steady_value;
         end
      endcase
   endfunction

   function automatic bit sender_idles();
      case (flow)
         FLOW_SEND_IDLE: return $urandom_range(99) < 56;
         FLOW_BOTH:      return $urandom_range(99) < 22;
         default:        return 1'b0;
      endcase
   endfunction

   function automatic bit receiver_stalls();
      case (flow)
         FLOW_RECV_STALL: return $urandom_range(99) < 56;
         FLOW_BOTH:       return $urandom_range(99) < 22;
         default:         return 1'b0;
      endcase
   endfunction

   task automatic report_mismatch(string what, sample_t want, sample_t got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("mismatch on %s: expected %h, got %h at %0t", what, want, got, $time);
   endtask

   task automatic send_sample(input sample_t s, output window_stats_t want);
      while (sender_idles()) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      do @(posedge clock); while (req_tready !== 1'b1);
      want = push_sample(s);
   endtask

   task automatic check_result();
      window_stats_t want;
      if (pending_stats.size() == 0) begin
         report_mismatch("unexpected result", '0, rsp_tdata[0 +: SAMPLE_BITS]);
         return;
      end
      want = pending_stats.pop_front();
      if (rsp_tdata[0 +: SAMPLE_BITS] !== want.mean)
         report_mismatch("window_mean", want.mean, rsp_tdata[0 +: SAMPLE_BITS]);
      if (rsp_tdata[SAMPLE_BITS +: SAMPLE_BITS] !== want.low_sample)
         report_mismatch("window_min", want.low_sample, rsp_tdata[SAMPLE_BITS +: SAMPLE_BITS]);
      if (rsp_tdata[2*SAMPLE_BITS +: SAMPLE_BITS] !== want.high_sample)
         report_mismatch("window_max", want.high_sample,
                         rsp_tdata[2*SAMPLE_BITS +: SAMPLE_BITS]);
      if (rsp_tdata[3*SAMPLE_BITS +: SAMPLE_BITS] !== want.pair_low)
         report_mismatch("pair_low", want.pair_low, rsp_tdata[3*SAMPLE_BITS +: SAMPLE_BITS]);
      if (rsp_tdata[4*SAMPLE_BITS +: SAMPLE_BITS] !== want.pair_high)
         report_mismatch("pair_high", want.pair_high, rsp_tdata[4*SAMPLE_BITS +: SAMPLE_BITS]);
      if (rsp_tuser[0] !== want.full)
         report_mismatch("window_full", sample_t'(want.full), sample_t'(rsp_tuser[0]));
   endtask

   // result side: random stalls, plus one long hold-off so the block backs up
   initial begin : result_sink
      forever begin
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         rsp_tready <= !receiver_stalls();
         @(posedge clock);
         if (!reset && rsp_tvalid === 1'b1 && rsp_tready) check_result();
      end
   end

   initial begin : sample_source
      int unsigned   k;
      window_stats_t want;
      wait (reset === 1'b0);
      @(posedge clock);
      for (k = 0; k < DIRECTED_ROWS; k++) begin
         send_sample(DIRECTED[k].sample, want);
         pending_stats.push_back(DIRECTED[k].typed ? DIRECTED[k].stats : want);
      end
      for (k = 0; k < RANDOM_SAMPLES; k++) begin
         flow = flow_t'((k / 100) % 4);
         if (k == HOLD_OFF_AT) hold_off_pending = 1'b1;
         send_sample(random_sample(), want);
         pending_stats.push_back(want);
      end
      req_tvalid <= 1'b0;
      flow = FLOW_FREE;
      while (pending_stats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_stats.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
